[sv/assert_macros.svh]
// Assertion macros for the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[sv/ctls_pkg.sv]
// Types and constants shared by the token scanner modules.
package ctls_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW  = 2;
	localparam int QCntW  = 3;

	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] len;
	} tok_t;

	// One or two tokens caused by a single source byte.
	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} pair_t;

endpackage

[sv/ctls_scan.sv]
// Front end: scanner state machine, one source byte per cycle while acc is high.
module ctls_scan import ctls_pkg::*; #(
	parameter logic [7:0] LenCap = 8'd255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] char_code,
	output logic       wr,
	output pair_t      wr_data
);

	localparam logic [3:0] M_IDLE   = 4'd0;
	localparam logic [3:0] M_IDENT  = 4'd1;
	localparam logic [3:0] M_INT    = 4'd2;
	localparam logic [3:0] M_FRAC   = 4'd3;
	localparam logic [3:0] M_STRING = 4'd4;
	localparam logic [3:0] M_CHAR1  = 4'd5;
	localparam logic [3:0] M_CHAR2  = 4'd6;
	localparam logic [3:0] M_SLASH  = 4'd7;
	localparam logic [3:0] M_LINE   = 4'd8;
	localparam logic [3:0] M_BLOCK  = 4'd9;
	localparam logic [3:0] M_BSTAR  = 4'd10;
	localparam logic [3:0] M_MINUS  = 4'd11;
	localparam logic [3:0] M_CMP    = 4'd12;

	localparam logic [4:0] K_EOF    = 5'd0;
	localparam logic [4:0] K_IDENT  = 5'd1;
	localparam logic [4:0] K_INT    = 5'd2;
	localparam logic [4:0] K_DOUBLE = 5'd3;
	localparam logic [4:0] K_STRING = 5'd4;
	localparam logic [4:0] K_CHAR   = 5'd5;
	localparam logic [4:0] K_PLUS   = 5'd6;
	localparam logic [4:0] K_MINUS  = 5'd7;
	localparam logic [4:0] K_STAR   = 5'd8;
	localparam logic [4:0] K_SLASH  = 5'd9;
	localparam logic [4:0] K_LPAREN = 5'd10;
	localparam logic [4:0] K_RPAREN = 5'd11;
	localparam logic [4:0] K_LBRACE = 5'd12;
	localparam logic [4:0] K_RBRACE = 5'd13;
	localparam logic [4:0] K_SEMI   = 5'd14;
	localparam logic [4:0] K_COMMA  = 5'd15;
	localparam logic [4:0] K_COLON  = 5'd16;
	localparam logic [4:0] K_ARROW  = 5'd17;
	localparam logic [4:0] K_ASSIGN = 5'd18;
	localparam logic [4:0] K_EQ     = 5'd19;
	localparam logic [4:0] K_NE     = 5'd20;
	localparam logic [4:0] K_LT     = 5'd21;
	localparam logic [4:0] K_LE     = 5'd22;
	localparam logic [4:0] K_GT     = 5'd23;
	localparam logic [4:0] K_GE     = 5'd24;
	localparam logic [4:0] K_ERROR  = 5'd25;

	// first character of a comparison operator
	localparam logic [1:0] P_EQ   = 2'd0;
	localparam logic [1:0] P_LT   = 2'd1;
	localparam logic [1:0] P_GT   = 2'd2;
	localparam logic [1:0] P_BANG = 2'd3;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] cnt;
		logic       ld_pend;
		logic [1:0] pend;
		logic       emit;
		tok_t       tok;
	} start_t;

	logic [3:0] mode_q, nxt_mode;
	logic [7:0] cnt_q, nxt_cnt, cnt_inc;
	logic [1:0] pend_q, nxt_pend;
	logic       pre_v, sec_v, restart;
	tok_t       pre_tok, sec_tok;
	start_t     st;
	logic       is_eq;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		return is_alpha(c) || c == 8'h24 || c == 8'h5f;
	endfunction

	function automatic logic is_printable(input logic [7:0] c);
		return c >= 8'd32 && c <= 8'd127;
	endfunction

	function automatic tok_t mk(input logic [4:0] k, input logic [7:0] l);
		tok_t t;
		t.kind = k;
		t.len  = l;
		return t;
	endfunction

	// Decide what a byte does when it opens a new token.
	function automatic start_t start_fn(input logic [7:0] c);
		start_t s;
		s.mode    = M_IDLE;
		s.cnt     = 8'd0;
		s.ld_pend = 1'b0;
		s.pend    = P_EQ;
		s.emit    = 1'b0;
		s.tok     = mk(K_ERROR, 8'd1);
		if (is_id_start(c)) begin
			s.mode = M_IDENT;
			s.cnt  = 8'd1;
		end else if (is_digit(c)) begin
			s.mode = M_INT;
			s.cnt  = 8'd1;
		end else begin
			case (c)
				8'h09, 8'h20, 8'h0a: ;
				8'h00: begin
					s.emit = 1'b1;
					s.tok  = mk(K_EOF, 8'd0);
				end
				8'h2f: s.mode = M_SLASH;
				8'h2d: s.mode = M_MINUS;
				8'h22: s.mode = M_STRING;
				8'h27: s.mode = M_CHAR1;
				8'h2b: begin s.emit = 1'b1; s.tok = mk(K_PLUS, 8'd1);   end
				8'h2a: begin s.emit = 1'b1; s.tok = mk(K_STAR, 8'd1);   end
				8'h28: begin s.emit = 1'b1; s.tok = mk(K_LPAREN, 8'd1); end
				8'h29: begin s.emit = 1'b1; s.tok = mk(K_RPAREN, 8'd1); end
				8'h7b: begin s.emit = 1'b1; s.tok = mk(K_LBRACE, 8'd1); end
				8'h7d: begin s.emit = 1'b1; s.tok = mk(K_RBRACE, 8'd1); end
				8'h3b: begin s.emit = 1'b1; s.tok = mk(K_SEMI, 8'd1);   end
				8'h2c: begin s.emit = 1'b1; s.tok = mk(K_COMMA, 8'd1);  end
				8'h3a: begin s.emit = 1'b1; s.tok = mk(K_COLON, 8'd1);  end
				8'h3d: begin s.mode = M_CMP; s.ld_pend = 1'b1; s.pend = P_EQ;   end
				8'h3c: begin s.mode = M_CMP; s.ld_pend = 1'b1; s.pend = P_LT;   end
				8'h3e: begin s.mode = M_CMP; s.ld_pend = 1'b1; s.pend = P_GT;   end
				8'h21: begin s.mode = M_CMP; s.ld_pend = 1'b1; s.pend = P_BANG; end
				default: s.emit = 1'b1;
			endcase
		end
		return s;
	endfunction

	assign st      = start_fn(char_code);
	assign cnt_inc = (cnt_q < LenCap) ? cnt_q + 8'd1 : cnt_q;
	assign is_eq   = (char_code == 8'h3d);

	always_comb begin
		nxt_mode = mode_q;
		nxt_cnt  = cnt_q;
		nxt_pend = pend_q;
		pre_v    = 1'b0;
		pre_tok  = mk(K_EOF, 8'd0);
		sec_v    = 1'b0;
		sec_tok  = mk(K_EOF, 8'd0);
		restart  = 1'b0;
		unique case (mode_q)
			M_IDENT: begin
				if (is_id_start(char_code) || is_digit(char_code)) begin
					nxt_cnt = cnt_inc;
				end else begin
					pre_v   = 1'b1;
					pre_tok = mk(K_IDENT, cnt_q);
					restart = 1'b1;
				end
			end
			M_INT: begin
				if (is_digit(char_code)) begin
					nxt_cnt = cnt_inc;
				end else if (char_code == 8'h2e) begin
					nxt_cnt  = cnt_inc;
					nxt_mode = M_FRAC;
				end else begin
					pre_v   = 1'b1;
					pre_tok = mk(K_INT, cnt_q);
					restart = 1'b1;
				end
			end
			M_FRAC: begin
				if (is_digit(char_code)) begin
					nxt_cnt = cnt_inc;
				end else begin
					pre_v   = 1'b1;
					pre_tok = mk(K_DOUBLE, cnt_q);
					restart = 1'b1;
				end
			end
			M_STRING: begin
				if (char_code != 8'h22 && is_printable(char_code)) begin
					nxt_cnt = cnt_inc;
				end else begin
					// closing quote, or a control/high byte cuts the string short
					pre_v    = 1'b1;
					pre_tok  = mk(K_STRING, cnt_q);
					nxt_mode = M_IDLE;
					sec_v    = (char_code == 8'h00);
				end
			end
			M_CHAR1: begin
				if (is_printable(char_code)) begin
					nxt_mode = M_CHAR2;
				end else begin
					pre_v   = 1'b1;
					pre_tok = mk(K_ERROR, 8'd1);
					restart = 1'b1;
				end
			end
			M_CHAR2: begin
				nxt_mode = M_IDLE;
				pre_v    = 1'b1;
				if (char_code == 8'h27) begin
					pre_tok = mk(K_CHAR, 8'd1);
				end else if (char_code == 8'h00) begin
					pre_tok = mk(K_ERROR, 8'd2);
					sec_v   = 1'b1;
				end else begin
					pre_tok = mk(K_ERROR, 8'd3);
				end
			end
			M_SLASH: begin
				if (char_code == 8'h2f) begin
					nxt_mode = M_LINE;
				end else if (char_code == 8'h2a) begin
					nxt_mode = M_BLOCK;
				end else begin
					pre_v   = 1'b1;
					pre_tok = mk(K_SLASH, 8'd1);
					restart = 1'b1;
				end
			end
			M_LINE: begin
				if (char_code == 8'h0a) begin
					nxt_mode = M_IDLE;
				end else if (char_code == 8'h00) begin
					nxt_mode = M_IDLE;
					pre_v    = 1'b1;
				end
			end
			M_BLOCK, M_BSTAR: begin
				if (char_code == 8'h00) begin
					nxt_mode = M_IDLE;
					pre_v    = 1'b1;
				end else if (char_code == 8'h2a) begin
					nxt_mode = M_BSTAR;
				end else if (char_code == 8'h2f && mode_q == M_BSTAR) begin
					nxt_mode = M_IDLE;
				end else begin
					nxt_mode = M_BLOCK;
				end
			end
			M_MINUS: begin
				pre_v = 1'b1;
				if (char_code == 8'h3e) begin
					pre_tok  = mk(K_ARROW, 8'd2);
					nxt_mode = M_IDLE;
				end else begin
					pre_tok = mk(K_MINUS, 8'd1);
					restart = 1'b1;
				end
			end
			M_CMP: begin
				pre_v = 1'b1;
				case (pend_q)
					P_EQ:    pre_tok = is_eq ? mk(K_EQ, 8'd2) : mk(K_ASSIGN, 8'd1);
					P_LT:    pre_tok = is_eq ? mk(K_LE, 8'd2) : mk(K_LT, 8'd1);
					P_GT:    pre_tok = is_eq ? mk(K_GE, 8'd2) : mk(K_GT, 8'd1);
					default: pre_tok = is_eq ? mk(K_NE, 8'd2) : mk(K_ERROR, 8'd1);
				endcase
				if (is_eq) begin
					nxt_mode = M_IDLE;
				end else begin
					restart = 1'b1;
				end
			end
			default: restart = 1'b1;
		endcase
		if (restart) begin
			nxt_mode = st.mode;
			nxt_cnt  = st.cnt;
			if (st.ld_pend) begin
				nxt_pend = st.pend;
			end
			sec_v   = st.emit;
			sec_tok = st.tok;
		end
	end

	always_comb begin
		wr         = acc && (pre_v || sec_v);
		wr_data.two = pre_v && sec_v;
		wr_data.t0  = pre_v ? pre_tok : sec_tok;
		wr_data.t1  = sec_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q  <= 8'd0;
			pend_q <= P_EQ;
		end else if (acc) begin
			mode_q <= nxt_mode;
			cnt_q  <= nxt_cnt;
			pend_q <= nxt_pend;
		end
	end

endmodule

[sv/ctls_fifo.sv]
// Short queue of token groups between scanner and output stage.
`include "assert_macros.svh"
module ctls_fifo import ctls_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  pair_t wr_data,
	input  logic  rd,
	output pair_t rd_data,
	output logic  full,
	output logic  empty
);

	pair_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign full    = (cnt_q == QCntW'(QDepth));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + QCntW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - QCntW'(1);
			end
		end
	end

	`ASSERT_NEVER(a_overflow, clk, arst_n, wr && full && !rd)
	`ASSERT_NEVER(a_underflow, clk, arst_n, rd && empty)
	`ASSERT_CLK(a_count_bound, clk, arst_n, cnt_q <= QCntW'(QDepth))

endmodule

[sv/ctls_emit.sv]
// Back end: hands out the one or two tokens of each queued group.
module ctls_emit import ctls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pair_t      head,
	input  logic       q_empty,
	input  logic       pop,
	output logic       q_rd,
	output logic [4:0] token_kind,
	output logic [7:0] token_length,
	output logic       last_of_run
);

	logic sel_q;
	logic take;
	tok_t cur;

	assign cur          = sel_q ? head.t1 : head.t0;
	assign token_kind   = cur.kind;
	assign token_length = cur.len;
	assign last_of_run  = sel_q || !head.two;
	assign take         = pop && !q_empty;
	assign q_rd         = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= !last_of_run;
		end
	end

endmodule

[sv/c_like_token_scanner_core.sv]
// Top level of the streaming token scanner.
//  channel   dir  handshake            payload
//  source    in   push / full          char_code
//  token     out  pop / empty          token_kind, token_length, last_of_run
// One source byte is taken per cycle while the four-entry group queue has room.
// Each byte queues zero, one or two tokens; the output side hands out one token
// per cycle while pop is high and the queue is not empty, and a group leaves the queue only with its last token.
// The scanner writes the tokens of each taken byte into the queue; full rises only when the queue fills.
// Reset returns the scanner to idle between tokens and empties the queue.
module c_like_token_scanner_core import ctls_pkg::*; #(
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       pop,
	output logic       empty,
	output logic [4:0] token_kind,
	output logic [7:0] token_length,
	output logic       last_of_run
);

	localparam logic [7:0] LenCap = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

	logic  acc, q_wr, q_rd;
	pair_t q_in, q_head;

	assign acc = push && !full;

	ctls_scan #(.LenCap(LenCap)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.char_code (char_code),
		.wr        (q_wr),
		.wr_data   (q_in)
	);

	ctls_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_in),
		.rd      (q_rd),
		.rd_data (q_head),
		.full    (full),
		.empty   (empty)
	);

	ctls_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (empty),
		.pop          (pop),
		.q_rd         (q_rd),
		.token_kind   (token_kind),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

[verif/ctls_tb_pkg.sv]
// Constants shared by the token scanner testbench files.
package ctls_tb_pkg;

	// Source byte that ends the input and yields an eof token.
	localparam logic [7:0] END_OF_INPUT = 8'h00;

endpackage

[verif/c_like_token_scanner_checker.sv]
// Token scanner checker: tracks both channels, predicts tokens and compares them.
module c_like_token_scanner_checker import ctls_tb_pkg::*; #(
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] char_code,
	input  logic       pop,
	input  logic       empty,
	input  logic [4:0] token_kind,
	input  logic [7:0] token_length,
	input  logic       last_of_run,
	output int         fail_count,
	output int         tokens_pending
);

	localparam int LenCap = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

	typedef enum logic [3:0] {
		SC_IDLE, SC_IDENT, SC_INT, SC_FRAC, SC_STRING, SC_CHAR_OPEN, SC_CHAR_BODY,
		SC_SLASH, SC_LINE_CMT, SC_BLOCK_CMT, SC_BLOCK_STAR, SC_MINUS, SC_CMP
	} scan_state_e;

	typedef enum logic [4:0] {
		TK_EOF, TK_IDENT, TK_INT, TK_DOUBLE, TK_STRING, TK_CHAR,
		TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_LPAREN, TK_RPAREN,
		TK_LBRACE, TK_RBRACE, TK_SEMI, TK_COMMA, TK_COLON, TK_ARROW,
		TK_ASSIGN, TK_EQ, TK_NE, TK_LT, TK_LE, TK_GT, TK_GE, TK_ERROR
	} tok_kind_e;

	typedef struct {
		logic [4:0] kind;
		logic [7:0] len;
		logic       last_of_run;
	} scan_token_t;

	scan_state_e mode;
	int          lex_len;
	logic [7:0]  cmp_first;
	scan_token_t byte_tokens[$];
	scan_token_t expected_tokens[$];
	int          n_fail = 0;
	int          n_pending = 0;

	assign fail_count     = n_fail;
	assign tokens_pending = n_pending;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_id_start(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "$" || c == "_";
	endfunction

	function automatic bit is_printable(logic [7:0] c);
		return c >= 8'd32 && c <= 8'd127;
	endfunction

	// A byte never yields more than two tokens; extras are dropped.
	function void emit(logic [4:0] kind, int len);
		scan_token_t t;
		t.kind        = kind;
		t.len         = 8'((len > LenCap) ? LenCap : len);
		t.last_of_run = 1'b0;
		if (byte_tokens.size() < 2)
			byte_tokens.insert(byte_tokens.size(), t);
	endfunction

	function void count_up();
		if (lex_len < LenCap)
			lex_len++;
	endfunction

	function void start_token(logic [7:0] c);
		mode    = SC_IDLE;
		lex_len = 0;
		case (c)
			"\t", " ", "\n": begin
			end
			END_OF_INPUT: emit(TK_EOF, 0);
			"/": mode = SC_SLASH;
			"-": mode = SC_MINUS;
			"+": emit(TK_PLUS, 1);
			"*": emit(TK_STAR, 1);
			"(": emit(TK_LPAREN, 1);
			")": emit(TK_RPAREN, 1);
			"{": emit(TK_LBRACE, 1);
			"}": emit(TK_RBRACE, 1);
			";": emit(TK_SEMI, 1);
			",": emit(TK_COMMA, 1);
			":": emit(TK_COLON, 1);
			"\"": mode = SC_STRING;
			"'": mode = SC_CHAR_OPEN;
			"=", "<", ">", "!": begin
				mode      = SC_CMP;
				cmp_first = c;
			end
			default: begin
				if (is_id_start(c)) begin
					mode    = SC_IDENT;
					lex_len = 1;
				end else if (is_digit(c)) begin
					mode    = SC_INT;
					lex_len = 1;
				end else begin
					emit(TK_ERROR, 1);
				end
			end
		endcase
	endfunction

	function void finish_cmp(logic [7:0] c);
		bit eq;
		eq = (c == "=");
		if (cmp_first == "=")
			emit(eq ? TK_EQ : TK_ASSIGN, eq ? 2 : 1);
		else if (cmp_first == "<")
			emit(eq ? TK_LE : TK_LT, eq ? 2 : 1);
		else if (cmp_first == ">")
			emit(eq ? TK_GE : TK_GT, eq ? 2 : 1);
		else
			emit(eq ? TK_NE : TK_ERROR, eq ? 2 : 1);
		if (eq)
			mode = SC_IDLE;
		else
			start_token(c);
	endfunction

	// Advance the scanner by one source byte and queue the tokens it ends.
	function void scan_byte(logic [7:0] c);
		byte_tokens.delete();
		case (mode)
			SC_IDENT: begin
				if (is_id_start(c) || is_digit(c)) begin
					count_up();
				end else begin
					emit(TK_IDENT, lex_len);
					start_token(c);
				end
			end
			SC_INT: begin
				if (is_digit(c)) begin
					count_up();
				end else if (c == ".") begin
					count_up();
					mode = SC_FRAC;
				end else begin
					emit(TK_INT, lex_len);
					start_token(c);
				end
			end
			SC_FRAC: begin
				if (is_digit(c)) begin
					count_up();
				end else begin
					emit(TK_DOUBLE, lex_len);
					start_token(c);
				end
			end
			SC_STRING: begin
				if (c == "\"") begin
					emit(TK_STRING, lex_len);
					mode = SC_IDLE;
				end else if (is_printable(c)) begin
					count_up();
				end else begin
					// unterminated: the stray byte is swallowed, but a NUL still yields eof
					emit(TK_STRING, lex_len);
					mode = SC_IDLE;
					if (c == END_OF_INPUT)
						emit(TK_EOF, 0);
				end
			end
			SC_CHAR_OPEN: begin
				if (is_printable(c)) begin
					mode = SC_CHAR_BODY;
				end else begin
					emit(TK_ERROR, 1);
					start_token(c);
				end
			end
			SC_CHAR_BODY: begin
				mode = SC_IDLE;
				if (c == "'") begin
					emit(TK_CHAR, 1);
				end else if (c == END_OF_INPUT) begin
					emit(TK_ERROR, 2);
					emit(TK_EOF, 0);
				end else begin
					emit(TK_ERROR, 3);
				end
			end
			SC_SLASH: begin
				if (c == "/") begin
					mode = SC_LINE_CMT;
				end else if (c == "*") begin
					mode = SC_BLOCK_CMT;
				end else begin
					emit(TK_SLASH, 1);
					start_token(c);
				end
			end
			SC_LINE_CMT: begin
				if (c == "\n") begin
					mode = SC_IDLE;
				end else if (c == END_OF_INPUT) begin
					mode = SC_IDLE;
					emit(TK_EOF, 0);
				end
			end
			SC_BLOCK_CMT, SC_BLOCK_STAR: begin
				if (c == END_OF_INPUT) begin
					mode = SC_IDLE;
					emit(TK_EOF, 0);
				end else if (c == "*") begin
					mode = SC_BLOCK_STAR;
				end else if (c == "/" && mode == SC_BLOCK_STAR) begin
					mode = SC_IDLE;
				end else begin
					mode = SC_BLOCK_CMT;
				end
			end
			SC_MINUS: begin
				if (c == ">") begin
					emit(TK_ARROW, 2);
					mode = SC_IDLE;
				end else begin
					emit(TK_MINUS, 1);
					start_token(c);
				end
			end
			SC_CMP: finish_cmp(c);
			default: start_token(c);
		endcase
		if (byte_tokens.size() > 0)
			byte_tokens[byte_tokens.size() - 1].last_of_run = 1'b1;
		foreach (byte_tokens[i])
			expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_token_t t;
		if (!arst_n) begin
			mode      = SC_IDLE;
			lex_len   = 0;
			cmp_first = 8'h00;
			expected_tokens.delete();
			n_pending = 0;
		end else begin
			// pop side first: a token leaving now is older than any byte taken now
			if (pop && !empty) begin
				if (expected_tokens.size() == 0) begin
					$error("token popped with none expected: kind %0d length %0d",
						token_kind, token_length);
					n_fail++;
				end else begin
					t = expected_tokens.pop_front();
					if (token_kind !== t.kind) begin
						$error("token_kind: expected %0d, got %0d", t.kind, token_kind);
						n_fail++;
					end
					if (token_length !== t.len) begin
						$error("token_length: expected %0d, got %0d", t.len, token_length);
						n_fail++;
					end
					if (last_of_run !== t.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d", t.last_of_run,
							last_of_run);
						n_fail++;
					end
				end
			end
			if (push && !full)
				scan_byte(char_code);
			n_pending = expected_tokens.size();
		end
	end

endmodule

[verif/c_like_token_scanner_core_tb.sv]
// Testbench top for the token scanner: clock, reset, source and sink traffic, verdict.
module c_like_token_scanner_core_tb;
	import ctls_tb_pkg::*;

	localparam int PhaseBytes  = 410;
	localparam int HoldCycles  = 60;
	localparam int DrainCycles = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [4:0] token_kind;
	logic [7:0] token_length;
	logic       last_of_run;
	int         fail_count;
	int         tokens_pending;

	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	logic       sink_hold = 1'b0;
	bit         hold_req = 1'b0;
	logic [7:0] src_bytes[$];

	always #5 clk = ~clk;

	c_like_token_scanner_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.pop          (pop),
		.empty        (empty),
		.token_kind   (token_kind),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	c_like_token_scanner_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.char_code      (char_code),
		.pop            (pop),
		.empty          (empty),
		.token_kind     (token_kind),
		.token_length   (token_length),
		.last_of_run    (last_of_run),
		.fail_count     (fail_count),
		.tokens_pending (tokens_pending)
	);

	always @(negedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
	end

	// Long sink hold-off while the source keeps pushing, so the token queue fills.
	initial begin
		wait (hold_req);
		@(negedge clk);
		sink_hold <= 1'b1;
		repeat (HoldCycles) @(negedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		#4000000;
		$display("c_like_token_scanner_core verification failed");
		$finish;
	end

	function automatic void add_byte(input logic [7:0] c);
		src_bytes.insert(src_bytes.size(), c);
	endfunction

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	function automatic void add_text(string s);
		foreach (s[i])
			add_byte(s[i]);
	endfunction

	function automatic logic [7:0] string_body_byte();
		logic [7:0] c;
		c = 8'($urandom_range(32, 127));
		while (c == "\"")
			c = 8'($urandom_range(32, 127));
		return c;
	endfunction

	function automatic logic [7:0] non_printable();
		case ($urandom_range(2))
			0: return END_OF_INPUT;
			1: return 8'($urandom_range(1, 31));
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	// One mostly well-formed lexeme with random content; some are deliberately broken.
	function automatic void add_random_lexeme();
		string id_start;
		string id_more;
		int    r;
		int    n;
		logic [7:0] c;
		id_start = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ$_";
		id_more  = {id_start, "0123456789"};
		r = $urandom_range(99);
		if (r < 14) begin
			n = ($urandom_range(99) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 8);
			add_byte(pick(id_start));
			repeat (n - 1) add_byte(pick(id_more));
		end else if (r < 24) begin
			repeat ($urandom_range(1, 5)) add_byte(pick("0123456789"));
			if ($urandom_range(1)) begin
				add_byte(".");
				repeat ($urandom_range(0, 4)) add_byte(pick("0123456789"));
			end
		end else if (r < 32) begin
			n = ($urandom_range(99) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 6);
			add_byte("\"");
			repeat (n) add_byte(string_body_byte());
			add_byte(($urandom_range(99) < 80) ? 8'h22 : non_printable());
		end else if (r < 40) begin
			add_byte("'");
			case ($urandom_range(9))
				0, 1: add_byte(non_printable());
				2: begin
					add_byte(8'($urandom_range(32, 127)));
					add_byte(END_OF_INPUT);
				end
				3: begin
					add_byte(8'($urandom_range(32, 127)));
					c = 8'($urandom_range(1, 255));
					while (c == "'")
						c = 8'($urandom_range(1, 255));
					add_byte(c);
				end
				default: begin
					add_byte(8'($urandom_range(32, 127)));
					add_byte("'");
				end
			endcase
		end else if (r < 47) begin
			if ($urandom_range(1)) begin
				add_text("//");
				repeat ($urandom_range(0, 6)) begin
					c = 8'($urandom_range(1, 255));
					add_byte((c == "\n") ? 8'h20 : c);
				end
				add_byte(($urandom_range(9) == 0) ? END_OF_INPUT : 8'h0a);
			end else begin
				add_text("/*");
				repeat ($urandom_range(0, 6)) add_byte(pick("ab */*\n-"));
				if ($urandom_range(9) == 0)
					add_byte(END_OF_INPUT);
				else
					add_text("*/");
			end
		end else if (r < 72) begin
			case ($urandom_range(3))
				0: begin
					case ($urandom_range(4))
						0: add_text("->");
						1: add_text("==");
						2: add_text("!=");
						3: add_text("<=");
						default: add_text(">=");
					endcase
				end
				default: add_byte(pick("+-*/(){};,:=<>!"));
			endcase
		end else if (r < 88) begin
			repeat ($urandom_range(1, 3)) add_byte(pick(" \t\n"));
		end else if (r < 96) begin
			add_byte(8'($urandom_range(255)));
		end else begin
			add_byte(END_OF_INPUT);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_byte(input logic [7:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			push      <= 1'b0;
			char_code <= 8'($urandom_range(255));
			@(negedge clk);
		end
		push      <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_all();
		while (src_bytes.size() > 0)
			send_byte(src_bytes.pop_front());
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ident, delayed ends, decimal, arrow, char, string, block comment,
		// bang then <=, high byte, eof
		add_text("a9 1.2->'c'\"s\"/**/!<=");
		add_byte(8'h80);
		add_byte(END_OF_INPUT);
		send_all();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
					hold_req       = 1'b1;
				end
				1: begin
					src_idle_pct   = 78;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 78;
				end
				default: begin
					src_idle_pct   = 36;
					sink_stall_pct = 36;
				end
			endcase
			while (src_bytes.size() < PhaseBytes)
				add_random_lexeme();
			send_all();
		end
		push <= 1'b0;

		wait (tokens_pending == 0);
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0 && tokens_pending == 0)
			$display("c_like_token_scanner_core verification clean");
		else
			$display("c_like_token_scanner_core verification failed");
		$finish;
	end

endmodule
